### design/assert_macros.svh
// Assertion macros for the port-level checker of the median filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SWM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds across reset.
`define SWM_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### design/swm_pkg.sv
// Package with widths and the command and status types of the median filter.
package swm_pkg;

    localparam int DATA_W    = 32;
    localparam int MAX_WIN   = 64;
    localparam int ADDR_W    = $clog2(MAX_WIN);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int WSIZE_W   = 7;
    localparam int WSIZE_RST = 3;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef struct packed {
        logic load;
        logic old_rd;
        logic old_cap;
        logic rm_start;
        logic rm_step;
        logic ins_start;
        logic ins_step;
        logic ins_first;
        logic finish;
        logic med_cap;
    } t_swm_cmd;

    typedef struct packed {
        logic full;
        logic has_res;
        logic rm_last;
        logic ins_empty;
        logic ins_stop;
        logic ins_zero;
    } t_swm_status;

endpackage

### design/swm_stream_if.sv
// Stream interfaces for the sample input and the median output.
interface swm_sample_if;
    import swm_pkg::*;

    logic  valid;
    logic  ready;
    t_data sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swm_median_if;
    import swm_pkg::*;

    logic  valid;
    logic  ready;
    t_data median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

### design/swm_ctrl.sv
// Controller state machine that sequences the remove, insert and median steps.
module swm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  swm_pkg::t_swm_status i_status,
    output swm_pkg::t_swm_cmd    o_cmd
);
    import swm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OLD_RD,
        S_OLD_CAP,
        S_REMOVE,
        S_INS_START,
        S_INSERT,
        S_INS_FIRST,
        S_FINISH,
        S_MED
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.full ? S_OLD_RD : S_INS_START;
                end
            end
            S_OLD_RD: begin
                o_cmd.old_rd = 1'b1;
                n_state      = S_OLD_CAP;
            end
            S_OLD_CAP: begin
                o_cmd.old_cap  = 1'b1;
                o_cmd.rm_start = 1'b1;
                n_state        = S_REMOVE;
            end
            S_REMOVE: begin
                o_cmd.rm_step = 1'b1;
                if (i_status.rm_last) begin
                    n_state = S_INS_START;
                end
            end
            S_INS_START: begin
                o_cmd.ins_start = 1'b1;
                n_state         = i_status.ins_empty ? S_INS_FIRST : S_INSERT;
            end
            S_INSERT: begin
                o_cmd.ins_step = 1'b1;
                if (i_status.ins_stop) begin
                    n_state = S_FINISH;
                end else if (i_status.ins_zero) begin
                    n_state = S_INS_FIRST;
                end
            end
            S_INS_FIRST: begin
                o_cmd.ins_first = 1'b1;
                n_state         = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = i_status.has_res ? S_MED : S_IDLE;
            end
            S_MED: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.med_cap = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### design/swm_dp.sv
// Datapath with the sample ring, the sorted store, the scan index and the window counters.
module swm_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  swm_pkg::t_swm_cmd     i_cmd,
    output swm_pkg::t_swm_status  o_status,
    input  logic                  i_cfg_we,
    input  logic [swm_pkg::WSIZE_W-1:0] i_cfg_wdata,
    input  swm_pkg::t_data        i_sample,
    output swm_pkg::t_data        o_median
);
    import swm_pkg::*;

    t_data r_sorted [MAX_WIN];
    t_data r_ring   [MAX_WIN];

    logic [WSIZE_W-1:0] r_wsize;
    logic [CNT_W-1:0]   r_fill;
    logic [ADDR_W-1:0]  r_slot;
    logic [ADDR_W-1:0]  r_idx;
    logic               r_found;

    t_data r_x;
    t_data r_old;
    t_data r_srd;
    t_data r_ring_rd;
    t_data r_med;

    logic [CNT_W-1:0]  k;
    logic [ADDR_W-1:0] km1;
    logic [CNT_W-1:0]  n_ins;
    logic [ADDR_W-1:0] med_addr;
    logic [CNT_W:0]    med_sum;
    logic [CNT_W:0]    slot_inc;
    logic              full;
    logic              greater;
    logic              match;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              we;
    logic [ADDR_W-1:0] wa;
    t_data             wd;

    always_comb begin
        if (r_wsize == '0) begin
            k = CNT_W'(1);
        end else if (r_wsize > WSIZE_W'(MAX_WIN)) begin
            k = CNT_W'(MAX_WIN);
        end else begin
            k = CNT_W'(r_wsize);
        end
    end

    assign km1      = ADDR_W'(k - CNT_W'(1));
    assign full     = (r_fill == k);
    assign n_ins    = full ? (k - CNT_W'(1)) : r_fill;
    assign med_sum  = ({1'b0, k} + (CNT_W + 1)'(1)) >> 1;
    assign med_addr = ADDR_W'(med_sum - (CNT_W + 1)'(1));
    assign slot_inc = {2'b00, r_slot} + (CNT_W + 1)'(1);
    assign greater  = (r_srd > r_x);
    assign match    = (r_srd == r_old);

    assign o_status.full      = full;
    assign o_status.has_res   = full || (CNT_W'(r_fill + CNT_W'(1)) == k);
    assign o_status.rm_last   = (r_idx == km1);
    assign o_status.ins_empty = (n_ins == '0);
    assign o_status.ins_stop  = !greater;
    assign o_status.ins_zero  = (r_idx == '0);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        we      = 1'b0;
        wa      = '0;
        wd      = r_x;
        if (i_cmd.rm_start) begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end
        if (i_cmd.rm_step) begin
            rd_en   = 1'b1;
            rd_addr = r_idx + ADDR_W'(1);
            if (r_found) begin
                we = 1'b1;
                wa = r_idx - ADDR_W'(1);
                wd = r_srd;
            end
        end
        if (i_cmd.ins_start) begin
            rd_en   = 1'b1;
            rd_addr = n_ins[ADDR_W-1:0] - ADDR_W'(1);
        end
        if (i_cmd.ins_step) begin
            we = 1'b1;
            wa = r_idx + ADDR_W'(1);
            if (greater) begin
                wd      = r_srd;
                rd_en   = 1'b1;
                rd_addr = r_idx - ADDR_W'(1);
            end else begin
                wd = r_x;
            end
        end
        if (i_cmd.ins_first) begin
            we = 1'b1;
            wa = '0;
            wd = r_x;
        end
        if (i_cmd.finish) begin
            rd_en   = 1'b1;
            rd_addr = med_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize <= WSIZE_W'(WSIZE_RST);
            r_fill  <= '0;
            r_slot  <= '0;
            r_idx   <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_wsize <= i_cfg_wdata;
                r_fill  <= '0;
                r_slot  <= '0;
            end else if (i_cmd.finish) begin
                if (full) begin
                    r_slot <= (slot_inc >= {1'b0, k}) ? '0 : ADDR_W'(slot_inc);
                end else begin
                    r_fill <= r_fill + CNT_W'(1);
                end
            end
            if (i_cmd.rm_start) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.rm_step) begin
                r_idx <= r_idx + ADDR_W'(1);
                if (!r_found && match) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.ins_start) begin
                r_idx <= n_ins[ADDR_W-1:0] - ADDR_W'(1);
            end
            if (i_cmd.ins_step && greater) begin
                r_idx <= r_idx - ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_sorted[wa] <= wd;
        end
        if (rd_en) begin
            r_srd <= r_sorted[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_ring[full ? r_slot : r_fill[ADDR_W-1:0]] <= r_x;
        end
        if (i_cmd.old_rd) begin
            r_ring_rd <= r_ring[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_sample;
        end
        if (i_cmd.old_cap) begin
            r_old <= r_ring_rd;
        end
        if (i_cmd.med_cap) begin
            r_med <= r_srd;
        end
    end

    assign o_median = r_med;

endmodule

### design/sliding_window_median_top.sv
// Top level of the sliding window median filter.
//
//   Channel   Direction  Payload           Handshake
//   i_smp     in         sample, 32 bits   valid / ready
//   o_med     out        median, 32 bits   valid / ready
//   i_cfg_*   in         window_size, 7    write enable only
//
// The work on each sample is paced by the single read port of the sorted store,
// which is scanned once to remove the oldest sample when the window is full and
// once to insert the new one.
// Reset sets the window size to 3 and empties the window; the stores are not cleared.
// One result waits in the output register while the next sample is processed;
// a second waits in the sorted store's read register and input is held off.
module sliding_window_median_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    swm_sample_if.sink                  i_smp,
    swm_median_if.source                o_med,
    input  logic                        i_cfg_we,
    input  logic [swm_pkg::WSIZE_W-1:0] i_cfg_wdata
);
    import swm_pkg::*;

    t_swm_cmd    cmd;
    t_swm_status status;
    logic        in_ready;
    logic        out_valid;
    t_data       median;

    swm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_smp.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_med.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    swm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (i_smp.sample),
        .o_median    (median)
    );

    assign i_smp.ready  = in_ready;
    assign o_med.valid  = out_valid;
    assign o_med.median = median;

endmodule

### design/swm_checker.sv
// Port-level checks of the median filter and their binding to the top level.
`include "assert_macros.svh"

module swm_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [swm_pkg::DATA_W-1:0] i_median
);
    import swm_pkg::*;

    logic in_xfer;
    logic out_stall;

    assign in_xfer   = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;

    `SWM_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> i_out_valid, "median dropped while stalled")
    `SWM_ASSERT(a_out_stable, i_clk, i_rst_n, out_stall |=> $stable(i_median), "median changed while stalled")
    `SWM_ASSERT(a_busy_after_in, i_clk, i_rst_n, in_xfer |=> !i_in_ready, "input taken while a sample is in work")
    `SWM_ASSERT(a_no_instant_out, i_clk, i_rst_n, in_xfer |=> !$rose(i_out_valid), "result too early after input transfer")
    `SWM_ASSERT_NR(a_ready_after_rst, i_clk, !i_rst_n |=> i_in_ready, "input not ready after reset")

endmodule

bind sliding_window_median_top swm_checker u_swm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_med.valid),
    .i_out_ready (o_med.ready),
    .i_median    (o_med.median)
);

### sim/swm_median_checker.sv
// Checker that predicts the running lower median and compares every output transfer.
`timescale 1ns / 1ps

module swm_median_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    swm_sample_if                       smp,
    swm_median_if                       med,
    input  logic                        i_cfg_we,
    input  logic [swm_pkg::WSIZE_W-1:0] i_cfg_wdata,
    input  logic                        i_end_of_test,
    output int                          o_pending,
    output int                          o_fail_count
);
    import swm_pkg::*;

    localparam int PRINT_CAP = 100;

    logic [WSIZE_W-1:0] window_reg;
    t_data              arrival_ring [MAX_WIN];
    t_data              ranked [$];
    t_data              expected_medians [$];
    int unsigned        fill_cnt;
    int unsigned        oldest_slot;
    int                 fail_count = 0;
    bit                 end_checked = 1'b0;
    t_data              want;

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_CAP) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    function automatic void clear_window();
        fill_cnt    = 0;
        oldest_slot = 0;
        ranked.delete();
    endfunction

    function automatic void insert_ranked(input t_data x);
        int pos;
        pos = ranked.size();
        while (pos > 0 && ranked[pos-1] > x) begin
            pos--;
        end
        ranked.insert(pos, x);
    endfunction

    // Takes one sample into the window and queues the median it causes, if any.
    function automatic void take_sample(input t_data x);
        int unsigned k;
        int          idx;
        if (window_reg == 0) begin
            k = 1;
        end else if (window_reg > MAX_WIN) begin
            k = MAX_WIN;
        end else begin
            k = window_reg;
        end
        if (fill_cnt < k) begin
            arrival_ring[fill_cnt] = x;
            insert_ranked(x);
            fill_cnt++;
            if (fill_cnt < k) begin
                return;
            end
        end else begin
            idx = 0;
            while (idx < ranked.size() && ranked[idx] != arrival_ring[oldest_slot]) begin
                idx++;
            end
            if (idx < ranked.size()) begin
                ranked.delete(idx);
            end
            insert_ranked(x);
            arrival_ring[oldest_slot] = x;
            oldest_slot = (oldest_slot + 1 >= k) ? 0 : oldest_slot + 1;
        end
        expected_medians.insert(expected_medians.size(), ranked[(k + 1) / 2 - 1]);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            window_reg = WSIZE_W'(WSIZE_RST);
            clear_window();
            expected_medians.delete();
        end else begin
            if (i_cfg_we) begin
                window_reg = i_cfg_wdata;
                clear_window();
            end
            if (smp.valid && smp.ready) begin
                take_sample(smp.sample);
            end
            if (med.valid && med.ready) begin
                if (expected_medians.size() == 0) begin
                    report_mismatch($sformatf("unexpected median %0d", med.median));
                end else begin
                    want = expected_medians.pop_front();
                    if (med.median !== want) begin
                        report_mismatch($sformatf("median got %0d, expected %0d",
                                                  med.median, want));
                    end
                end
            end
            if (i_end_of_test && !end_checked) begin
                end_checked = 1'b1;
                if (expected_medians.size() != 0) begin
                    report_mismatch($sformatf("%0d medians never arrived",
                                              expected_medians.size()));
                end
            end
        end
        o_pending    <= expected_medians.size();
        o_fail_count <= fail_count;
    end

endmodule

### sim/tb_top.sv
// Testbench top that drives samples and window settings into the median filter.
`timescale 1ns / 1ps

module tb_top;
    import swm_pkg::*;

    localparam int    DRAIN_CYCLES = 2 * MAX_WIN + 80;
    localparam int    LONG_STALL   = 600;
    localparam int    TIMEOUT_NS   = 4_000_000;
    localparam t_data DATA_MIN     = {1'b1, {(DATA_W-1){1'b0}}};
    localparam t_data DATA_MAX     = {1'b0, {(DATA_W-1){1'b1}}};
    localparam int    N_DIRECTED   = 22;
    localparam t_data DIRECTED [N_DIRECTED] = '{
        DATA_MIN, DATA_MAX, 0, -1, 1, DATA_MAX, DATA_MIN, DATA_MIN, DATA_MAX, 0,
        0, 0, 32'h5555_5555, 32'hAAAA_AAAA, -2, 2, DATA_MAX - 1, DATA_MIN + 1,
        7, 7, -7, 7
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [WSIZE_W-1:0] i_cfg_wdata;
    logic               end_of_test;
    logic               long_stall_req;
    int                 pending_medians;
    int                 fail_count;
    int                 src_idle_pct;
    int                 snk_idle_pct;

    swm_sample_if smp_if ();
    swm_median_if med_if ();

    sliding_window_median_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_smp       (smp_if),
        .o_med       (med_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    swm_median_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .smp           (smp_if),
        .med           (med_if),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_end_of_test (end_of_test),
        .o_pending     (pending_medians),
        .o_fail_count  (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #1 i_clk = ~i_clk;
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

    // The receiver idles at random; on request it holds off for a long counted stretch.
    initial begin
        med_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_stall_req) begin
                med_if.ready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
                long_stall_req <= 1'b0;
            end else begin
                med_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    function automatic t_data pick_sample();
        case ($urandom_range(3))
            0: return t_data'(int'($urandom_range(8)) - 4);
            1: begin
                case ($urandom_range(3))
                    0: return DATA_MIN;
                    1: return DATA_MAX;
                    2: return 0;
                    default: return -1;
                endcase
            end
            default: return t_data'($urandom);
        endcase
    endfunction

    task automatic send_sample(input t_data value);
        while ($urandom_range(99) < src_idle_pct) begin
            smp_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_if.valid  <= 1'b1;
        smp_if.sample <= value;
        @(posedge i_clk);
        while (!smp_if.ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_for_medians();
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_medians != 0) begin
            @(posedge i_clk);
        end
    endtask

    // The block may still be busy with a sample that causes no median, so wait it out.
    task automatic wait_idle();
        wait_for_medians();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [WSIZE_W-1:0] wsize, input int items,
                             input bit hold_receiver, input bit pause_midway);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= wsize;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (hold_receiver) begin
            long_stall_req <= 1'b1;
        end
        for (int i = 0; i < items; i++) begin
            if (pause_midway && i == items / 2) begin
                wait_for_medians();
            end
            send_sample(pick_sample());
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        smp_if.valid   <= 1'b0;
        smp_if.sample  <= '0;
        end_of_test    <= 1'b0;
        long_stall_req <= 1'b0;
        src_idle_pct   = 20;
        snk_idle_pct   = 66;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_sample(DIRECTED[i]);
        end
        run_phase(0, 100, 1'b0, 1'b0);
        run_phase(2, 100, 1'b0, 1'b0);
        run_phase(64, 30, 1'b0, 1'b0);
        run_phase(64, 150, 1'b0, 1'b0);
        run_phase(5, 150, 1'b1, 1'b0);

        src_idle_pct = 66;
        snk_idle_pct = 20;
        run_phase(127, 130, 1'b0, 1'b0);
        run_phase(1, 100, 1'b0, 1'b0);
        run_phase(4, 150, 1'b0, 1'b1);
        run_phase(10, 6, 1'b0, 1'b0);
        run_phase(10, 60, 1'b0, 1'b0);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_phase(65, 130, 1'b0, 1'b0);
        run_phase(3, 150, 1'b0, 1'b0);
        run_phase(16, 150, 1'b0, 1'b0);
        run_phase(33, 120, 1'b0, 1'b0);
        run_phase(WSIZE_W'($urandom_range(1, 12)), 150, 1'b0, 1'b0);

        wait_idle();
        end_of_test <= 1'b1;
        repeat (3) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
